/* hw/rtl/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths and controller/datapath interface types for the lookahead
// point selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

	// coordinate and register formats
	localparam int COORD_WIDTH = 24;
	localparam int LOOK_WIDTH  = 24;
	localparam int SUM_WIDTH   = 32;

	// segment length arithmetic
	localparam int MAG_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH = 2 * MAG_WIDTH;
	localparam int SQ_WIDTH   = PROD_WIDTH + 1;
	localparam int SQS_WIDTH  = (SQ_WIDTH > 65) ? SQ_WIDTH : 65;
	localparam int RAD_LIMIT  = (SQ_WIDTH < 64) ? SQ_WIDTH : 64;
	localparam int ROOT_WIDTH = (RAD_LIMIT + 1) / 2;
	localparam int RAD_WIDTH  = 2 * ROOT_WIDTH;
	localparam int REM_WIDTH  = ROOT_WIDTH + 2;
	localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH);

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic drop;
		logic load_diff;
		logic sq_x;
		logic sq_y;
		logic root_init;
		logic root_step;
		logic accum;
		logic finish;
	} lps_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic found;
		logic have_prev;
		logic root_last;
		logic emit;
		logic out_busy;
	} lps_status_t;

endpackage

`default_nettype wire

/* hw/rtl/lps_datapath.sv */
// ----------------------------------------------------------------------------
// lps_datapath
// Path state, segment length unit (shared squarer and a two-bit-per-cycle
// square root), saturating arc length accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire lps_pkg::lps_cmd_t                     cmd,
	output lps_pkg::lps_status_t                       status,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [lps_pkg::LOOK_WIDTH-1:0]        cfg_wr_data,
	input  wire logic signed [lps_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [lps_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic                                  last_point,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [lps_pkg::COORD_WIDTH-1:0]     target_x,
	output logic signed [lps_pkg::COORD_WIDTH-1:0]     target_y,
	output logic                                       from_path_end
);
	import lps_pkg::*;

	logic [LOOK_WIDTH-1:0]         lookahead_q;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q;
	logic                          last_q;
	logic [SUM_WIDTH-1:0]          sum_q;
	logic                          have_prev_q, found_q;
	logic [MAG_WIDTH-1:0]          dx_q, dy_q;
	logic [SQS_WIDTH-1:0]          sq_q;
	logic [RAD_WIDTH-1:0]          rad_q;
	logic [REM_WIDTH-1:0]          rem_q;
	logic [ROOT_WIDTH-1:0]         root_q;
	logic [CNT_WIDTH-1:0]          cnt_q;
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;
	logic                          out_end_q;

	logic signed [MAG_WIDTH-1:0] diff_x, diff_y;
	logic [MAG_WIDTH-1:0]        abs_x, abs_y, sq_op;
	logic [PROD_WIDTH-1:0]       prod;
	logic [REM_WIDTH-1:0]        rem_wide, trial;
	logic                        root_ge;
	logic                        sq_ovf;
	logic [SUM_WIDTH:0]          len_ext, sum_total;
	logic                        hit;

	// coordinate differences and magnitudes
	always_comb begin
		diff_x = MAG_WIDTH'(cur_x_q) - MAG_WIDTH'(prev_x_q);
		diff_y = MAG_WIDTH'(cur_y_q) - MAG_WIDTH'(prev_y_q);
		abs_x  = diff_x[MAG_WIDTH-1] ? MAG_WIDTH'(-diff_x) : MAG_WIDTH'(diff_x);
		abs_y  = diff_y[MAG_WIDTH-1] ? MAG_WIDTH'(-diff_y) : MAG_WIDTH'(diff_y);
	end

	// one squarer shared by both axes
	assign sq_op = cmd.sq_y ? dy_q : dx_q;
	assign prod  = sq_op * sq_op;

	// square root digit step
	assign rem_wide = {rem_q[REM_WIDTH-3:0], rad_q[RAD_WIDTH-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign root_ge  = rem_wide >= trial;

	// saturating length add
	assign sq_ovf    = |sq_q[SQS_WIDTH-1:64];
	assign len_ext   = (SUM_WIDTH + 1)'(root_q);
	assign sum_total = {1'b0, sum_q} + len_ext;

	// target test against the running distance
	assign hit = have_prev_q && (sum_q >= SUM_WIDTH'(lookahead_q));

	assign status.found     = found_q;
	assign status.have_prev = have_prev_q;
	assign status.root_last = cnt_q == CNT_WIDTH'(ROOT_WIDTH - 1);
	assign status.emit      = hit || last_q;
	assign status.out_busy  = out_valid_q && out_stall;

	// configuration and path control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			sum_q       <= '0;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lookahead_q <= cfg_wr_data;
			end
			// path end returns the path state to reset
			if ((cmd.finish || cmd.drop) && last_q) begin
				prev_x_q    <= '0;
				prev_y_q    <= '0;
				sum_q       <= '0;
				have_prev_q <= 1'b0;
				found_q     <= 1'b0;
			end else begin
				if (cmd.accum) begin
					if (sq_ovf || sum_total[SUM_WIDTH]) begin
						sum_q <= '1;
					end else begin
						sum_q <= sum_total[SUM_WIDTH-1:0];
					end
				end
				if (cmd.finish) begin
					found_q     <= hit;
					prev_x_q    <= cur_x_q;
					prev_y_q    <= cur_y_q;
					have_prev_q <= 1'b1;
				end
			end
			// result beat handshake
			if (cmd.finish && (hit || last_q)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the length unit
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_x_q <= point_x;
			cur_y_q <= point_y;
			last_q  <= last_point;
		end
		if (cmd.load_diff) begin
			dx_q <= abs_x;
			dy_q <= abs_y;
		end
		if (cmd.sq_x) begin
			sq_q <= SQS_WIDTH'(prod);
		end
		if (cmd.sq_y) begin
			sq_q <= sq_q + SQS_WIDTH'(prod);
		end
		if (cmd.root_init) begin
			rad_q  <= sq_q[RAD_WIDTH-1:0];
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end
		if (cmd.root_step) begin
			rad_q  <= {rad_q[RAD_WIDTH-3:0], 2'b00};
			rem_q  <= root_ge ? rem_wide - trial : rem_wide;
			root_q <= {root_q[ROOT_WIDTH-2:0], root_ge};
			cnt_q  <= cnt_q + CNT_WIDTH'(1);
		end
		if (cmd.finish && (hit || last_q)) begin
			out_x_q   <= cur_x_q;
			out_y_q   <= cur_y_q;
			out_end_q <= !hit;
		end
	end

	assign out_valid     = out_valid_q;
	assign target_x      = out_x_q;
	assign target_y      = out_y_q;
	assign from_path_end = out_end_q;

endmodule

`default_nettype wire

/* hw/rtl/lps_ctrl.sv */
// ----------------------------------------------------------------------------
// lps_ctrl
// Sequencer for one path point: accept, drop it past the target, else segment
// length, accumulate, and hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output lps_pkg::lps_cmd_t          cmd,
	input  wire lps_pkg::lps_status_t  status
);
	import lps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQX,
		ST_SQY,
		ST_RINIT,
		ST_ROOT,
		ST_ACC,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	// commands decoded from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load_in   = in_valid;
			ST_CHECK: begin
				cmd.drop      = status.found;
				cmd.load_diff = !status.found && status.have_prev;
			end
			ST_SQX:    cmd.sq_x      = 1'b1;
			ST_SQY:    cmd.sq_y      = 1'b1;
			ST_RINIT:  cmd.root_init = 1'b1;
			ST_ROOT:   cmd.root_step = 1'b1;
			ST_ACC:    cmd.accum     = 1'b1;
			ST_FINISH: cmd.finish    = !(status.emit && status.out_busy);
			default:   cmd = '0;
		endcase
	end

	// state and input stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_CHECK;
						in_stall_q <= 1'b1;
					end
				end
				ST_CHECK: begin
					if (status.found) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end else if (status.have_prev) begin
						state_q <= ST_SQX;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SQX:   state_q <= ST_SQY;
				ST_SQY:   state_q <= ST_RINIT;
				ST_RINIT: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (status.root_last) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC:   state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!(status.emit && status.out_busy)) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall = in_stall_q;

endmodule

`default_nettype wire

/* hw/rtl/lookahead_point_select.sv */
// ----------------------------------------------------------------------------
// lookahead_point_select
// Picks the first point of a streamed path whose arc length from the path
// start reaches the configured lookahead distance.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel: one path point per beat (in_valid/in_stall), signed
//    coordinates plus last_point marking the end of a path
//  - output channel: at most one beat per path (out_valid/out_stall) with the
//    selected point; from_path_end is set when the path ran out first
//  - cfg_wr_en/cfg_wr_data write the lookahead distance; write it only while
//    the block is idle
//  - a point with a previous point is worked through the check state, the
//    shared squarer (x, then y), root setup, 26 square root iterations (two
//    radicand bits each), accumulate and finish
//  - the first point of a path goes from the check state straight to finish
//  - one point is worked on at a time: in_stall stays high from acceptance
//    until the point leaves its finish state, or is dropped in the check
//    state once its path has found its target
//  - reset clears the path state, the lookahead distance and the output beat
//  - a stalled result beat holds; the next point is still accepted and worked
//    on, and only waits in its finish cycle if it also has a result to send
// ----------------------------------------------------------------------------
`default_nettype none

module lookahead_point_select (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [lps_pkg::LOOK_WIDTH-1:0]         cfg_wr_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [lps_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [lps_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic                                   last_point,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [lps_pkg::COORD_WIDTH-1:0]      target_x,
	output logic signed [lps_pkg::COORD_WIDTH-1:0]      target_y,
	output logic                                        from_path_end
);
	import lps_pkg::*;

	lps_cmd_t    cmd;
	lps_status_t status;

	// sequencer
	lps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// arithmetic and path state
	lps_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.point_x       (point_x),
		.point_y       (point_y),
		.last_point    (last_point),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.target_x      (target_x),
		.target_y      (target_y),
		.from_path_end (from_path_end)
	);

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lookahead_point_select. Path points go in over the
// valid/stall input channel and a local predictor works out the selected
// target of each path. Every target beat is checked field by field against
// the oldest outstanding prediction. Directed paths cover the boundary cases
// and a long receiver hold-off fills the block. Random paths then run under
// several lookahead settings, with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
module tb;
	import lps_pkg::*;

	localparam int CW          = COORD_WIDTH;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 48;
	localparam int HOLD_CYCLES = 300;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   at_end;
	} target_t;

	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [LOOK_WIDTH-1:0] LOOK_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [LOOK_WIDTH-1:0] cfg_wr_data;
	logic                  in_valid;
	logic                  in_stall;
	coord_t                point_x;
	coord_t                point_y;
	logic                  last_point;
	logic                  out_valid;
	logic                  out_stall;
	coord_t                target_x;
	coord_t                target_y;
	logic                  from_path_end;

	lookahead_point_select u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.target_x     (target_x),
		.target_y     (target_y),
		.from_path_end(from_path_end)
	);

	// predictor state
	logic [LOOK_WIDTH-1:0] lookahead_reg;
	coord_t                trail_x;
	coord_t                trail_y;
	logic [SUM_WIDTH-1:0]  arc_sum;
	logic                  trail_open;
	logic                  target_sent;
	target_t               targets_due[$];

	// bookkeeping
	int errors;
	int cycles;
	int n_points;
	int n_paths;
	int n_targets;
	int n_end_targets;
	int n_in_stall;
	int n_settings;
	int burst_left;
	int hold_left;
	int stall_mode;
	int stall_phase_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_error(input string what, input longint got, input longint want);
		errors++;
		if (errors <= 30)
			$display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// integer square root, one result bit per trial
	function automatic logic [SUM_WIDTH-1:0] seg_length(coord_t ax, coord_t ay, coord_t bx,
			coord_t by);
		longint          dx;
		longint          dy;
		longint unsigned sq;
		longint unsigned root;
		longint unsigned trial;
		dx   = longint'(bx) - longint'(ax);
		dy   = longint'(by) - longint'(ay);
		sq   = longint'(dx * dx + dy * dy);
		root = 0;
		for (int b = 26; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= sq)
				root = trial;
		end
		return root[SUM_WIDTH-1:0];
	endfunction

	// advance the path state by one accepted point
	function automatic void predict_point(coord_t x, coord_t y, logic last);
		logic [SUM_WIDTH:0] total;
		target_t            t;
		logic               hit;
		hit      = 1'b0;
		t.x      = x;
		t.y      = y;
		t.at_end = 1'b0;
		if (!target_sent) begin
			if (trail_open) begin
				total   = {1'b0, arc_sum} + seg_length(trail_x, trail_y, x, y);
				arc_sum = total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
				if (arc_sum >= lookahead_reg) begin
					target_sent = 1'b1;
					hit         = 1'b1;
				end
			end
			if (!hit && last) begin
				hit      = 1'b1;
				t.at_end = 1'b1;
			end
			trail_x    = x;
			trail_y    = y;
			trail_open = 1'b1;
		end
		if (hit)
			targets_due.push_back(t);
		if (last) begin
			trail_x     = '0;
			trail_y     = '0;
			arc_sum     = '0;
			trail_open  = 1'b0;
			target_sent = 1'b0;
			n_paths++;
		end
	endfunction

	// target beat checker
	always @(posedge clk) begin
		target_t want;
		if (arst_n && in_valid && in_stall)
			n_in_stall++;
		if (arst_n && out_valid && !out_stall) begin
			n_targets++;
			if (from_path_end)
				n_end_targets++;
			if (targets_due.size() == 0) begin
				report_error("target beat with none pending", {target_x, target_y}, 0);
			end else begin
				want = targets_due.pop_front();
				if (target_x !== want.x)
					report_error("target_x", target_x, want.x);
				if (target_y !== want.y)
					report_error("target_y", target_y, want.y);
				if (from_path_end !== want.at_end)
					report_error("from_path_end", from_path_end, want.at_end);
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	initial begin
		out_stall        = 1'b0;
		stall_mode       = 0;
		stall_phase_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				if (stall_phase_left == 0) begin
					stall_mode       = $urandom_range(0, 2);
					stall_phase_left = $urandom_range(20, 200);
				end
				stall_phase_left--;
				case (stall_mode)
					1: begin
						out_stall = ($urandom_range(0, 3) == 0);
					end
					2: begin
						out_stall = ($urandom_range(0, 3) != 0);
					end
					default: begin
						out_stall = 1'b0;
					end
				endcase
			end
		end
	end

	// offer one point and wait until it is accepted; bursts with random gaps between
	task automatic send_point(input coord_t x, input coord_t y, input logic last);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		in_valid   = 1'b1;
		point_x    = x;
		point_y    = y;
		last_point = last;
		do @(posedge clk); while (in_stall);
		burst_left--;
		n_points++;
		predict_point(x, y, last);
	endtask

	// stop offering, let every target arrive, then let the block settle
	task automatic drain;
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
		while (targets_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_lookahead(input logic [LOOK_WIDTH-1:0] look_dist);
		drain();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = look_dist;
		@(negedge clk);
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = LOOK_WIDTH'($urandom());
		lookahead_reg = look_dist;
		n_settings++;
	endtask

	task automatic test_single_point;
		send_point(C_MAX, C_MIN, 1'b1);
		send_point(C_MIN, C_MAX, 1'b1);
		send_point('0, '0, 1'b1);
	endtask

	task automatic test_zero_lookahead;
		set_lookahead('0);
		// zero-length segment still reaches a zero lookahead
		send_point(24'sd5, 24'sd5, 1'b0);
		send_point(24'sd5, 24'sd5, 1'b1);
		send_point(-24'sd1, -24'sd1, 1'b0);
		send_point(24'sd1, 24'sd1, 1'b0);
		send_point(24'sd9, 24'sd9, 1'b1);
	endtask

	task automatic test_points_after_target;
		set_lookahead(24'd4096);
		send_point('0, '0, 1'b0);
		send_point(24'sd8192, '0, 1'b0);
		send_point(24'sd100, 24'sd100, 1'b0);
		send_point(C_MAX, C_MIN, 1'b0);
		send_point(24'sd3, 24'sd3, 1'b1);
		// target lands exactly on the last point
		send_point('0, '0, 1'b0);
		send_point(24'sd2048, '0, 1'b0);
		send_point(24'sd4096, '0, 1'b1);
	endtask

	task automatic test_long_lookahead;
		set_lookahead(LOOK_MAX);
		// diagonal corner to corner overshoots the largest lookahead
		send_point(C_MIN, C_MIN, 1'b0);
		send_point(C_MAX, C_MAX, 1'b1);
		// full-width step equals the lookahead exactly
		send_point(C_MIN, '0, 1'b0);
		send_point(C_MAX, '0, 1'b1);
		// one unit short, so the path runs out
		send_point(C_MIN, '0, 1'b0);
		send_point(CW'(C_MAX - 1), '0, 1'b1);
	endtask

	task automatic test_backpressure;
		set_lookahead('0);
		hold_left  = HOLD_CYCLES;
		burst_left = 32;
		for (int i = 0; i < 24; i++)
			send_point(CW'($urandom()), CW'($urandom()), 1'b1);
	endtask

	function automatic coord_t next_coord(coord_t prev);
		int r;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				r = 1 << $urandom_range(4, 12);
			end
			4, 5, 6: begin
				r = 1 << $urandom_range(13, 18);
			end
			7: begin
				return CW'($urandom());
			end
			8: begin
				case ($urandom_range(0, 2))
					0: return C_MAX;
					1: return C_MIN;
					default: return '0;
				endcase
			end
			default: begin
				r = 1 << $urandom_range(19, 23);
			end
		endcase
		return CW'(prev + ($urandom_range(0, 2 * r) - r));
	endfunction

	task automatic test_random_paths(input logic [LOOK_WIDTH-1:0] look_dist, input int n_items);
		int     sent;
		int     len;
		coord_t x;
		coord_t y;
		set_lookahead(look_dist);
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			x   = CW'($urandom());
			y   = CW'($urandom());
			for (int i = 0; i < len; i++) begin
				send_point(x, y, i == len - 1);
				x = next_coord(x);
				y = next_coord(y);
			end
			sent += len;
		end
	endtask

	initial begin
		errors        = 0;
		cycles        = 0;
		n_points      = 0;
		n_paths       = 0;
		n_targets     = 0;
		n_end_targets = 0;
		n_in_stall    = 0;
		n_settings    = 0;
		burst_left    = 0;
		hold_left     = 0;
		lookahead_reg = '0;
		trail_x       = '0;
		trail_y       = '0;
		arc_sum       = '0;
		trail_open    = 1'b0;
		target_sent   = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		point_x       = '0;
		point_y       = '0;
		last_point    = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_point();
		test_zero_lookahead();
		test_points_after_target();
		test_long_lookahead();
		test_backpressure();
		test_random_paths(24'd40960, 110);
		test_random_paths('0, 90);
		test_random_paths(LOOK_MAX, 90);
		test_random_paths(LOOK_WIDTH'($urandom_range(4096, 65536)), 110);
		test_random_paths(LOOK_WIDTH'($urandom()), 80);
		test_random_paths(24'd1, 70);
		drain();

		$display("covered %0d points in %0d paths under %0d lookahead settings",
			n_points, n_paths, n_settings);
		$display("checked %0d target beats, %0d from path end; input stalled %0d cycles",
			n_targets, n_end_targets, n_in_stall);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/lps_pkg.sv
hw/rtl/lps_datapath.sv
hw/rtl/lps_ctrl.sv
hw/rtl/lookahead_point_select.sv
sim/tb.sv
